### src/rmsd_pkg.sv
package rmsd_pkg;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [2:0] FMT_VAR   = 3'd2;
    localparam logic [2:0] FMT_VFC   = 3'd3;
    localparam logic [2:0] FMT_STMCR = 3'd6;

    localparam logic [2:0] FMT_RESET = FMT_VAR;

    localparam logic REG_RECORD_FORMAT = 1'b0;
    localparam logic REG_BLOCK_MODE    = 1'b1;

    typedef enum logic [5:0] {
        PH_LEN_LO = 6'b000001,
        PH_LEN_HI = 6'b000010,
        PH_VFC_A  = 6'b000100,
        PH_VFC_B  = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_PAD    = 6'b100000
    } phase_t;

endpackage

### src/rms_record_to_stream_lf_core.sv
// An item's first result is offered from the result register after the item has
// left the input register. One item per cycle while out_stall is low and each item
// yields at most one result; an item that yields a record byte plus a newline makes
// the item behind it wait in the input register while the two-entry result register
// drains one result per cycle while out_stall is low.
// Reset (rst_n low, asynchronous): format = variable, block mode off, parser at length
// low byte, input and result registers empty.
module rms_record_to_stream_lf_core
    import rmsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       buffer_end,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] text_byte,
    output logic       run_last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [2:0] cfg_data
);

    logic [2:0]  record_format_reg;
    logic        block_mode_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [7:0]  length_low_reg, length_low_next;
    logic        odd_record_reg, odd_record_next;

    logic [1:0]  cnt_reg;
    logic [7:0]  slot0_byte_reg;
    logic        slot0_last_reg;
    logic [7:0]  slot1_byte_reg;

    logic [1:0]  res_n;
    logic [7:0]  res0;
    logic [7:0]  res1;
    logic        parse_en;
    logic [15:0] len_full;
    logic [15:0] len_vfc;
    logic [15:0] left_dec;
    logic        pop;
    logic        out_free;
    logic        move;
    logic        in_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_format_reg <= FMT_RESET;
            block_mode_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RECORD_FORMAT: record_format_reg <= cfg_data;
                REG_BLOCK_MODE:    block_mode_reg    <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign parse_en = block_mode_reg &&
                      (record_format_reg == FMT_VAR || record_format_reg == FMT_VFC);
    assign len_full = {s1_byte_reg, length_low_reg};
    assign len_vfc  = (len_full < 16'd2) ? 16'd0 : len_full - 16'd2;
    assign left_dec = bytes_left_reg - 16'd1;

    always_comb
    begin
        res_n           = 2'd0;
        res0            = s1_byte_reg;
        res1            = CH_LF;
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        length_low_next = length_low_reg;
        odd_record_next = odd_record_reg;
        if (!block_mode_reg)
        begin
            res_n = s1_last_reg ? 2'd2 : 2'd1;
        end
        else if (parse_en)
        begin
            unique case (phase_reg)
                PH_LEN_HI:
                begin
                    if (record_format_reg == FMT_VFC)
                    begin
                        bytes_left_next = len_vfc;
                        odd_record_next = len_vfc[0];
                        phase_next      = PH_VFC_A;
                    end
                    else
                    begin
                        bytes_left_next = len_full;
                        odd_record_next = len_full[0];
                        if (len_full == 16'd0)
                        begin
                            res_n      = 2'd1;
                            res0       = CH_LF;
                            phase_next = PH_LEN_LO;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_VFC_A:
                begin
                    phase_next = PH_VFC_B;
                end
                PH_VFC_B:
                begin
                    if (bytes_left_reg == 16'd0)
                    begin
                        res_n      = 2'd1;
                        res0       = CH_LF;
                        phase_next = PH_LEN_LO;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    bytes_left_next = left_dec;
                    if (left_dec == 16'd0)
                    begin
                        res_n      = 2'd2;
                        phase_next = odd_record_reg ? PH_PAD : PH_LEN_LO;
                    end
                    else
                    begin
                        res_n = 2'd1;
                    end
                end
                PH_PAD:
                begin
                    phase_next = PH_LEN_LO;
                end
                default:
                begin
                    length_low_next = s1_byte_reg;
                    phase_next      = PH_LEN_HI;
                end
            endcase
        end
        else if (record_format_reg == FMT_STMCR)
        begin
            res_n = 2'd1;
            res0  = (s1_byte_reg == CH_CR) ? CH_LF : s1_byte_reg;
        end
        else
        begin
            res_n = 2'd1;
        end
    end

    // the held item leaves when the result register has room, or when it yields nothing
    assign pop      = out_valid && !out_stall;
    assign out_free = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
    assign move     = s1_valid_reg && (out_free || res_n == 2'd0);
    assign in_stall = s1_valid_reg && !move;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            phase_reg      <= PH_LEN_LO;
            bytes_left_reg <= 16'd0;
            length_low_reg <= 8'd0;
            odd_record_reg <= 1'b0;
            cnt_reg        <= 2'd0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (move)
            begin
                phase_reg      <= phase_next;
                bytes_left_reg <= bytes_left_next;
                length_low_reg <= length_low_next;
                odd_record_reg <= odd_record_next;
            end

            if (move && res_n != 2'd0)
            begin
                cnt_reg <= res_n;
            end
            else if (pop)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= buffer_end;
        end

        if (move && res_n != 2'd0)
        begin
            slot0_byte_reg <= res0;
            slot0_last_reg <= (res_n == 2'd1);
            slot1_byte_reg <= res1;
        end
        else if (pop)
        begin
            slot0_byte_reg <= slot1_byte_reg;
            slot0_last_reg <= 1'b1;
        end
    end

    assign out_valid = (cnt_reg != 2'd0);
    assign text_byte = slot0_byte_reg;
    assign run_last  = slot0_last_reg;

endmodule

### src/rmsd_checker.sv
module rmsd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] text_byte,
    input logic       run_last,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // a stalled output transaction keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(text_byte) && $stable(run_last))
        else $error("output transaction changed while stalled");

    // input back-pressure only comes from results waiting downstream
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result pending");

    // a result that is not the last of its run always has its follower stored
    a_run_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !run_last |=> out_valid)
        else $error("run ended without a last result");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind rms_record_to_stream_lf_core rmsd_checker u_rmsd_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .text_byte (text_byte),
    .run_last  (run_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
